// ----- rtl/core/typed_stack_machine_execute_defines.svh -----
// Assertion macros for the typed stack machine execute unit
`ifndef TYPED_STACK_MACHINE_EXECUTE_DEFINES_SVH
`define TYPED_STACK_MACHINE_EXECUTE_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define TSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define TSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/tsme_pkg.sv -----
// Shared types, codes and sizes for the typed stack machine execute unit
package tsme_pkg;
  localparam int StackDepth = 64;
  localparam int ReturnDepth = 16;
  localparam int AddressBits = 16;
  localparam int SpBits = $clog2(StackDepth + 1);
  localparam int SaBits = $clog2(StackDepth);
  localparam int RpBits = $clog2(ReturnDepth + 1);
  localparam int RaBits = $clog2(ReturnDepth);

  typedef enum logic [4:0] {
    OP_DROP = 5'd0, OP_DUP = 5'd1, OP_LDTRUE = 5'd2, OP_LDFALSE = 5'd3,
    OP_LDC = 5'd4, OP_LDI = 5'd5, OP_CHR = 5'd6, OP_INT = 5'd7, OP_BOOL = 5'd8,
    OP_INV = 5'd9, OP_ADD = 5'd10, OP_SUB = 5'd11, OP_MUL = 5'd12,
    OP_IDIV = 5'd13, OP_MOD = 5'd14, OP_AND = 5'd15, OP_OR = 5'd16,
    OP_NOT = 5'd17, OP_XOR = 5'd18, OP_SHL = 5'd19, OP_SHR = 5'd20,
    OP_EQU = 5'd21, OP_NEQ = 5'd22, OP_GT = 5'd23, OP_LT = 5'd24,
    OP_GEQ = 5'd25, OP_LEQ = 5'd26, OP_BR = 5'd27, OP_BRT = 5'd28,
    OP_BRF = 5'd29, OP_CALL = 5'd30, OP_RET = 5'd31
  } op_t;

  localparam logic [1:0] T_INT = 2'd0;
  localparam logic [1:0] T_BOOL = 2'd1;
  localparam logic [1:0] T_CHAR = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TYPE = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_OVER = 3'd3;
  localparam logic [2:0] ST_DIVZ = 3'd4;
  localparam logic [2:0] ST_RET = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat, start operand reads
    logic exec;      // operands valid, evaluate
    logic div_start; // start divider
    logic commit;    // write back and produce result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;
endpackage

// ----- rtl/core/typed_stack_machine_execute.sv -----
// Steps: operands are read from the stack when the beat is taken, evaluated in
// exec (idiv and mod then wait on the iterative divider), and written back at
// commit, which also registers the result beat; instructions complete in order.
// The next beat is taken once the previous result beat has been delivered.
// Reset (rst, synchronous) empties both stacks; stack contents are not cleared.
// Top level of the typed stack machine execute unit
`include "typed_stack_machine_execute_defines.svh"
module typed_stack_machine_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [4:0] operation, [36:5] immediate, [52:37] current_address, rest zero
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] status, [3] branch_taken, [19:4] branch_target, [51:20] top_value,
  // [53:52] top_type, [60:54] depth, rest zero
  output logic [63:0] m_tdata
);
  tsme_pkg::cmd_t cmd;
  tsme_pkg::sts_t sts;
  logic [2:0] status;
  logic branch_taken;
  logic [15:0] branch_target;
  logic [31:0] top_value;
  logic [1:0] top_type;
  logic [6:0] depth;

  tsme_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .sts(sts)
  );

  tsme_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(s_tdata[4:0]), .immediate(s_tdata[36:5]),
    .current_address(s_tdata[52:37]),
    .status(status), .branch_taken(branch_taken), .branch_target(branch_target),
    .top_value(top_value), .top_type(top_type), .depth(depth)
  );

  assign m_tdata = {3'd0, depth, top_type, top_value, branch_target, branch_taken, status};

  `TSM_ASSERT_IMP(a_no_take_busy, m_tvalid, !s_tready, "input taken while result pending")
  `TSM_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid, "commit without result beat")
  `TSM_ASSERT_IMP(a_depth_range, m_tvalid, depth <= 7'(tsme_pkg::StackDepth), "depth out of range")
endmodule

// ----- rtl/core/tsme_div.sv -----
// Iterative 32-bit signed divider, one quotient bit per cycle
module tsme_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [31:0] q;
  logic [32:0] r;
  logic [31:0] d;
  logic [5:0] count;
  logic busy;
  logic neg_q, neg_r;
  logic [32:0] trial;

  assign trial = {r[31:0], q[31]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd32;
        q <= dividend[31] ? 32'(-dividend) : dividend;
        d <= divisor[31] ? 32'(-divisor) : divisor;
        r <= '0;
        neg_q <= dividend[31] ^ divisor[31];
        neg_r <= dividend[31];
      end else if (busy) begin
        if (!trial[32]) begin
          r <= trial;
          q <= {q[30:0], 1'b1};
        end else begin
          r <= {r[31:0], q[31]};
          q <= {q[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg_q ? 32'(-q) : q;
  assign remainder = neg_r ? 32'(-r[31:0]) : r[31:0];
endmodule

// ----- rtl/core/tsme_datapath.sv -----
// Datapath: stacks, operand registers, ALU and result register
module tsme_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  tsme_pkg::cmd_t        cmd,
  output tsme_pkg::sts_t        sts,
  input  logic [4:0]            operation,
  input  logic signed [31:0]    immediate,
  input  logic [15:0]           current_address,
  output logic [2:0]            status,
  output logic                  branch_taken,
  output logic [15:0]           branch_target,
  output logic signed [31:0]    top_value,
  output logic [1:0]            top_type,
  output logic [6:0]            depth
);
  localparam int SpB = tsme_pkg::SpBits;
  localparam int SaB = tsme_pkg::SaBits;
  localparam int RpB = tsme_pkg::RpBits;
  localparam int RaB = tsme_pkg::RaBits;
  localparam int AB = tsme_pkg::AddressBits;

  logic [33:0] vmem [tsme_pkg::StackDepth];
  logic [15:0] rmem [tsme_pkg::ReturnDepth];
  logic [SpB-1:0] sp;
  logic [RpB-1:0] rp;

  tsme_pkg::op_t op;
  logic [31:0] imm;
  logic [15:0] addr;
  logic [33:0] ea, eb, below;
  logic [15:0] ret_addr;

  // top after step: kept in registers so result needs no extra read
  logic [31:0] tv;
  logic [1:0] tt;

  logic [SaB-1:0] ia, ib;
  logic [RaB-1:0] ir;
  assign ib = SaB'(sp - SpB'(1));
  assign ia = SaB'(sp - SpB'(2));
  assign ir = RaB'(rp - RpB'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= tsme_pkg::op_t'(operation);
      imm <= immediate;
      addr <= current_address;
      eb <= vmem[ib];
      ea <= vmem[ia];
      ret_addr <= rmem[ir];
    end
  end

  // divider
  logic div_done;
  logic [31:0] quo, rem;
  tsme_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(ea[31:0]), .divisor(eb[31:0]),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  // product, registered in exec
  logic signed [63:0] prod;
  always_ff @(posedge clk) begin
    if (cmd.exec) prod <= $signed(ea[31:0]) * $signed(eb[31:0]);
  end

  assign sts.need_div = (op == tsme_pkg::OP_IDIV || op == tsme_pkg::OP_MOD) && sp >= SpB'(2)
    && ea[33:32] == tsme_pkg::T_INT && eb[33:32] == tsme_pkg::T_INT && eb[31:0] != '0;
  assign sts.div_done = div_done;

  logic [2:0] st;
  logic tk;
  logic [15:0] tg;
  logic [1:0] kind; // 0 none, 1 push, 2 pop, 3 replace2 (pop and rewrite)
  logic rep1;
  logic [31:0] rv;
  logic [1:0] rt;
  logic rpush, rpop;
  logic [32:0] sum;
  logic signed [32:0] ka, kb;
  logic has1, has2, full, ints, cmp;
  logic [31:0] av, bv;
  logic [1:0] at, bt;

  always_comb begin
    av = ea[31:0]; bv = eb[31:0];
    at = ea[33:32]; bt = eb[33:32];
    has1 = sp >= SpB'(1);
    has2 = sp >= SpB'(2);
    full = sp >= SpB'(tsme_pkg::StackDepth);
    ints = at == tsme_pkg::T_INT && bt == tsme_pkg::T_INT;
    st = tsme_pkg::ST_OK; tk = 1'b0; tg = '0;
    kind = 2'd0; rep1 = 1'b0; rv = '0; rt = '0;
    rpush = 1'b0; rpop = 1'b0; sum = '0; cmp = 1'b0;
    ka = (at == tsme_pkg::T_INT) ? {av[31], av} : {1'b0, av};
    kb = (bt == tsme_pkg::T_INT) ? {bv[31], bv} : {1'b0, bv};
    unique case (op)
      tsme_pkg::OP_DROP: if (!has1) st = tsme_pkg::ST_UNDER; else kind = 2'd2;
      tsme_pkg::OP_DUP: begin
        if (!has1) st = tsme_pkg::ST_UNDER;
        else if (full) st = tsme_pkg::ST_OVER;
        else begin kind = 2'd1; rv = bv; rt = bt; end
      end
      tsme_pkg::OP_LDTRUE, tsme_pkg::OP_LDFALSE, tsme_pkg::OP_LDC,
      tsme_pkg::OP_LDI: begin
        if (full) st = tsme_pkg::ST_OVER;
        else begin
          kind = 2'd1;
          unique case (op)
            tsme_pkg::OP_LDTRUE: begin rv = 32'd1; rt = tsme_pkg::T_BOOL; end
            tsme_pkg::OP_LDFALSE: begin rv = '0; rt = tsme_pkg::T_BOOL; end
            tsme_pkg::OP_LDC: begin rv = {24'd0, imm[7:0]}; rt = tsme_pkg::T_CHAR; end
            default: begin rv = imm; rt = tsme_pkg::T_INT; end
          endcase
        end
      end
      tsme_pkg::OP_CHR, tsme_pkg::OP_INT, tsme_pkg::OP_BOOL, tsme_pkg::OP_INV,
      tsme_pkg::OP_NOT: begin
        if (!has1) st = tsme_pkg::ST_UNDER;
        else begin
          rv = bv; rt = bt;
          unique case (op)
            tsme_pkg::OP_CHR:
              if (bt != tsme_pkg::T_INT) st = tsme_pkg::ST_TYPE;
              else begin rv = {24'd0, bv[7:0]}; rt = tsme_pkg::T_CHAR; end
            tsme_pkg::OP_INT:
              if (bt != tsme_pkg::T_BOOL && bt != tsme_pkg::T_CHAR) st = tsme_pkg::ST_TYPE;
              else rt = tsme_pkg::T_INT;
            tsme_pkg::OP_BOOL:
              if (bt != tsme_pkg::T_INT) st = tsme_pkg::ST_TYPE;
              else begin rv = {31'd0, bv != '0}; rt = tsme_pkg::T_BOOL; end
            tsme_pkg::OP_INV:
              if (bt != tsme_pkg::T_INT) st = tsme_pkg::ST_TYPE;
              else if (bv == 32'h8000_0000) st = tsme_pkg::ST_OVER;
              else rv = 32'(-bv);
            default:
              if (bt == tsme_pkg::T_INT) rv = ~bv;
              else if (bt == tsme_pkg::T_BOOL) rv = {31'd0, bv == '0};
              else st = tsme_pkg::ST_TYPE;
          endcase
          rep1 = st == tsme_pkg::ST_OK;
        end
      end
      tsme_pkg::OP_BR: begin tk = 1'b1; tg = 16'(imm[AB-1:0]); end
      tsme_pkg::OP_BRT, tsme_pkg::OP_BRF: begin
        if (!has1) st = tsme_pkg::ST_UNDER;
        else if (bt != tsme_pkg::T_BOOL) st = tsme_pkg::ST_TYPE;
        else begin
          kind = 2'd2;
          if ((bv != '0) == (op == tsme_pkg::OP_BRT)) begin
            tk = 1'b1; tg = 16'(imm[AB-1:0]);
          end
        end
      end
      tsme_pkg::OP_CALL: begin
        if (rp >= RpB'(tsme_pkg::ReturnDepth)) st = tsme_pkg::ST_RET;
        else begin rpush = 1'b1; tk = 1'b1; tg = 16'(imm[AB-1:0]); end
      end
      tsme_pkg::OP_RET: begin
        if (rp == '0) st = tsme_pkg::ST_RET;
        else begin rpop = 1'b1; tk = 1'b1; tg = ret_addr; end
      end
      default: begin
        if (!has2) st = tsme_pkg::ST_UNDER;
        else begin
          rt = tsme_pkg::T_INT;
          unique case (op)
            tsme_pkg::OP_ADD, tsme_pkg::OP_SUB: begin
              if (!ints) st = tsme_pkg::ST_TYPE;
              else begin
                sum = (op == tsme_pkg::OP_ADD) ? {av[31], av} + {bv[31], bv}
                                               : {av[31], av} - {bv[31], bv};
                if (sum[32] != sum[31]) st = tsme_pkg::ST_OVER;
                rv = sum[31:0];
              end
            end
            tsme_pkg::OP_MUL: begin
              if (!ints) st = tsme_pkg::ST_TYPE;
              else begin
                if (prod[63:31] != {33{prod[31]}}) st = tsme_pkg::ST_OVER;
                rv = prod[31:0];
              end
            end
            tsme_pkg::OP_IDIV, tsme_pkg::OP_MOD: begin
              if (!ints) st = tsme_pkg::ST_TYPE;
              else if (bv == '0) st = tsme_pkg::ST_DIVZ;
              else if (op == tsme_pkg::OP_IDIV) begin
                if (av == 32'h8000_0000 && bv == '1) st = tsme_pkg::ST_OVER;
                rv = quo;
              end else rv = (bv == '1) ? '0 : rem;
            end
            tsme_pkg::OP_SHL: begin
              if (!ints) st = tsme_pkg::ST_TYPE;
              else rv = (bv >= 32'd32) ? '0 : av << bv[4:0];
            end
            tsme_pkg::OP_SHR: begin
              if (!ints) st = tsme_pkg::ST_TYPE;
              else rv = $signed(av) >>> ((bv >= 32'd32) ? 5'd31 : bv[4:0]);
            end
            tsme_pkg::OP_AND, tsme_pkg::OP_OR, tsme_pkg::OP_XOR: begin
              if (at != bt || (at != tsme_pkg::T_INT && at != tsme_pkg::T_BOOL))
                st = tsme_pkg::ST_TYPE;
              else begin
                rt = at;
                rv = (op == tsme_pkg::OP_AND) ? av & bv :
                     (op == tsme_pkg::OP_OR) ? av | bv : av ^ bv;
              end
            end
            default: begin
              if (at != bt || at > tsme_pkg::T_CHAR) st = tsme_pkg::ST_TYPE;
              else begin
                unique case (op)
                  tsme_pkg::OP_EQU: cmp = ka == kb;
                  tsme_pkg::OP_NEQ: cmp = ka != kb;
                  tsme_pkg::OP_GT: cmp = ka > kb;
                  tsme_pkg::OP_LT: cmp = ka < kb;
                  tsme_pkg::OP_GEQ: cmp = ka >= kb;
                  default: cmp = ka <= kb;
                endcase
                rv = {31'd0, cmp}; rt = tsme_pkg::T_BOOL;
              end
            end
          endcase
          if (st == tsme_pkg::ST_OK) kind = 2'd3;
        end
      end
    endcase
  end

  // new-top after a pop is the entry below; read it in exec
  always_ff @(posedge clk) begin
    if (cmd.exec) below <= vmem[SaB'(sp - SpB'(2))];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (kind == 2'd1) vmem[SaB'(sp)] <= {rt, rv};
      else if (kind == 2'd3) vmem[ia] <= {rt, rv};
      else if (rep1) vmem[ib] <= {rt, rv};
      if (rpush) rmem[RaB'(rp)] <= 16'(16'(addr + 16'd1) & 16'((1 << AB) - 1));
    end
  end

  logic [SpB-1:0] sp_new;
  always_comb begin
    unique case (kind)
      2'd1: sp_new = sp + SpB'(1);
      2'd2, 2'd3: sp_new = sp - SpB'(1);
      default: sp_new = sp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      rp <= '0;
      tv <= '0;
      tt <= '0;
    end else if (cmd.commit) begin
      sp <= sp_new;
      if (rpush) rp <= rp + RpB'(1);
      else if (rpop) rp <= rp - RpB'(1);
      if (kind == 2'd1 || kind == 2'd3 || rep1) begin
        tv <= rv; tt <= rt;
      end else if (kind == 2'd2) begin
        if (sp >= SpB'(2)) begin tv <= below[31:0]; tt <= below[33:32]; end
        else begin tv <= '0; tt <= '0; end
      end
      status <= st;
      branch_taken <= tk;
      branch_target <= tg;
      top_value <= (kind == 2'd1 || kind == 2'd3 || rep1) ? rv :
                   (kind == 2'd2) ? ((sp >= SpB'(2)) ? below[31:0] : '0) : tv;
      top_type <= (kind == 2'd1 || kind == 2'd3 || rep1) ? rt :
                  (kind == 2'd2) ? ((sp >= SpB'(2)) ? below[33:32] : '0) : tt;
      depth <= 7'(sp_new);
    end
  end
endmodule

// ----- rtl/core/tsme_ctrl.sv -----
// Controller: sequences load, execute, divide wait and result handshake
module tsme_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tsme_pkg::cmd_t cmd,
  input  tsme_pkg::sts_t sts
);
  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_FIN, S_OUT} state_t;
  state_t state;

  logic take;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign take = in_valid && in_ready;

  always_comb begin
    cmd.load = take;
    cmd.exec = state == S_EXEC;
    cmd.div_start = state == S_EXEC && sts.need_div;
    cmd.commit = state == S_FIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (take) state <= S_EXEC;
        S_EXEC: state <= sts.need_div ? S_DIV : S_FIN;
        S_DIV: if (sts.div_done) state <= S_FIN;
        S_FIN: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the typed stack machine execute unit
module testbench;
  typedef struct packed {
    logic [2:0]  status;
    logic        taken;
    logic [15:0] target;
    logic [31:0] top_value;
    logic [1:0]  top_type;
    logic [6:0]  depth;
  } outcome_t;

  class exec_scoreboard;
    logic [31:0] vals[tsme_pkg::StackDepth];
    logic [1:0]  tags[tsme_pkg::StackDepth];
    int unsigned sp;
    logic [15:0] rets[tsme_pkg::ReturnDepth];
    int unsigned rp;
    outcome_t    pending[$];
    int          errors;

    function void clear();
      sp = 0;
      rp = 0;
      pending.delete();
      errors = 0;
    endfunction

    function logic [2:0] push(logic [31:0] v, logic [1:0] t);
      if (sp >= tsme_pkg::StackDepth) return tsme_pkg::ST_OVER;
      vals[sp] = v;
      tags[sp] = t;
      sp++;
      return tsme_pkg::ST_OK;
    endfunction

    function logic [2:0] binary(tsme_pkg::op_t op, output logic [31:0] rv,
                                output logic [1:0] rt);
      logic [31:0] a, b;
      logic [1:0]  ta, tb;
      longint      x, y, r;
      bit          c;
      a = vals[sp-2]; b = vals[sp-1]; ta = tags[sp-2]; tb = tags[sp-1];
      x = longint'($signed(a)); y = longint'($signed(b));
      rv = '0; rt = tsme_pkg::T_INT; r = 0;
      case (op)
        tsme_pkg::OP_ADD, tsme_pkg::OP_SUB, tsme_pkg::OP_MUL, tsme_pkg::OP_IDIV,
        tsme_pkg::OP_MOD, tsme_pkg::OP_SHL, tsme_pkg::OP_SHR: begin
          if (ta != tsme_pkg::T_INT || tb != tsme_pkg::T_INT) return tsme_pkg::ST_TYPE;
          case (op)
            tsme_pkg::OP_ADD: r = x + y;
            tsme_pkg::OP_SUB: r = x - y;
            tsme_pkg::OP_MUL: r = x * y;
            tsme_pkg::OP_IDIV: begin
              if (y == 0) return tsme_pkg::ST_DIVZ;
              r = x / y;
            end
            tsme_pkg::OP_MOD: begin
              if (y == 0) return tsme_pkg::ST_DIVZ;
              r = (y == -1) ? 0 : x % y;
            end
            tsme_pkg::OP_SHL: begin
              rv = (b >= 32) ? 32'd0 : a << b;
              return tsme_pkg::ST_OK;
            end
            default: begin
              rv = $signed(a) >>> ((b >= 32) ? 31 : b);
              return tsme_pkg::ST_OK;
            end
          endcase
          if (r < -64'sd2147483648 || r > 64'sd2147483647) return tsme_pkg::ST_OVER;
          rv = r[31:0];
          return tsme_pkg::ST_OK;
        end
        tsme_pkg::OP_AND, tsme_pkg::OP_OR, tsme_pkg::OP_XOR: begin
          if (ta != tb || (ta != tsme_pkg::T_INT && ta != tsme_pkg::T_BOOL))
            return tsme_pkg::ST_TYPE;
          rt = ta;
          rv = (op == tsme_pkg::OP_AND) ? (a & b) :
               (op == tsme_pkg::OP_OR) ? (a | b) : (a ^ b);
          return tsme_pkg::ST_OK;
        end
        default: begin
          if (ta != tb || ta > tsme_pkg::T_CHAR) return tsme_pkg::ST_TYPE;
          if (ta != tsme_pkg::T_INT) begin
            x = longint'(a); y = longint'(b);
          end
          case (op)
            tsme_pkg::OP_EQU: c = x == y;
            tsme_pkg::OP_NEQ: c = x != y;
            tsme_pkg::OP_GT:  c = x > y;
            tsme_pkg::OP_LT:  c = x < y;
            tsme_pkg::OP_GEQ: c = x >= y;
            default: c = x <= y;
          endcase
          rv = {31'd0, c};
          rt = tsme_pkg::T_BOOL;
          return tsme_pkg::ST_OK;
        end
      endcase
    endfunction

    function void note_instruction(tsme_pkg::op_t op, logic [31:0] imm, logic [15:0] addr);
      outcome_t o;
      logic [31:0] rv;
      logic [1:0]  rt;
      int unsigned t;
      o = '0;
      t = sp - 1;
      case (op)
        tsme_pkg::OP_DROP: if (sp == 0) o.status = tsme_pkg::ST_UNDER; else sp--;
        tsme_pkg::OP_DUP: if (sp == 0) o.status = tsme_pkg::ST_UNDER;
                          else o.status = push(vals[t], tags[t]);
        tsme_pkg::OP_LDTRUE: o.status = push(32'd1, tsme_pkg::T_BOOL);
        tsme_pkg::OP_LDFALSE: o.status = push(32'd0, tsme_pkg::T_BOOL);
        tsme_pkg::OP_LDC: o.status = push({24'd0, imm[7:0]}, tsme_pkg::T_CHAR);
        tsme_pkg::OP_LDI: o.status = push(imm, tsme_pkg::T_INT);
        tsme_pkg::OP_CHR, tsme_pkg::OP_INT, tsme_pkg::OP_BOOL, tsme_pkg::OP_INV,
        tsme_pkg::OP_NOT: begin
          if (sp == 0) o.status = tsme_pkg::ST_UNDER;
          else case (op)
            tsme_pkg::OP_CHR:
              if (tags[t] != tsme_pkg::T_INT) o.status = tsme_pkg::ST_TYPE;
              else begin vals[t] &= 32'hff; tags[t] = tsme_pkg::T_CHAR; end
            tsme_pkg::OP_INT:
              if (tags[t] == tsme_pkg::T_INT) o.status = tsme_pkg::ST_TYPE;
              else tags[t] = tsme_pkg::T_INT;
            tsme_pkg::OP_BOOL:
              if (tags[t] != tsme_pkg::T_INT) o.status = tsme_pkg::ST_TYPE;
              else begin vals[t] = {31'd0, vals[t] != 0}; tags[t] = tsme_pkg::T_BOOL; end
            tsme_pkg::OP_INV:
              if (tags[t] != tsme_pkg::T_INT) o.status = tsme_pkg::ST_TYPE;
              else if (vals[t] == 32'h8000_0000) o.status = tsme_pkg::ST_OVER;
              else vals[t] = -vals[t];
            default:
              if (tags[t] == tsme_pkg::T_INT) vals[t] = ~vals[t];
              else if (tags[t] == tsme_pkg::T_BOOL) vals[t] = {31'd0, vals[t] == 0};
              else o.status = tsme_pkg::ST_TYPE;
          endcase
        end
        tsme_pkg::OP_BR: begin o.taken = 1'b1; o.target = imm[15:0]; end
        tsme_pkg::OP_BRT, tsme_pkg::OP_BRF: begin
          if (sp == 0) o.status = tsme_pkg::ST_UNDER;
          else if (tags[t] != tsme_pkg::T_BOOL) o.status = tsme_pkg::ST_TYPE;
          else begin
            if ((vals[t] != 0) == (op == tsme_pkg::OP_BRT)) begin
              o.taken = 1'b1; o.target = imm[15:0];
            end
            sp--;
          end
        end
        tsme_pkg::OP_CALL: if (rp >= tsme_pkg::ReturnDepth) o.status = tsme_pkg::ST_RET;
                 else begin
                   rets[rp] = addr + 16'd1; rp++;
                   o.taken = 1'b1; o.target = imm[15:0];
                 end
        tsme_pkg::OP_RET: if (rp == 0) o.status = tsme_pkg::ST_RET;
                else begin rp--; o.taken = 1'b1; o.target = rets[rp]; end
        default: begin
          if (sp < 2) o.status = tsme_pkg::ST_UNDER;
          else begin
            o.status = binary(op, rv, rt);
            if (o.status == tsme_pkg::ST_OK) begin
              sp--; vals[sp-1] = rv; tags[sp-1] = rt;
            end
          end
        end
      endcase
      if (sp > 0) begin
        o.top_value = vals[sp-1]; o.top_type = tags[sp-1];
      end
      o.depth = 7'(sp);
      pending.push_back(o);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [63:0] d);
      outcome_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", d[31:0], 32'd0);
        return;
      end
      e = pending.pop_front();
      if (d[2:0] != e.status) report("status", 32'(d[2:0]), 32'(e.status));
      if (d[3] != e.taken) report("branch_taken", 32'(d[3]), 32'(e.taken));
      if (d[19:4] != e.target) report("branch_target", 32'(d[19:4]), 32'(e.target));
      if (d[51:20] != e.top_value) report("top_value", d[51:20], e.top_value);
      if (d[53:52] != e.top_type) report("top_type", 32'(d[53:52]), 32'(e.top_type));
      if (d[60:54] != e.depth) report("depth", 32'(d[60:54]), 32'(e.depth));
      if (d[63:61] != 0) report("pad", 32'(d[63:61]), 32'd0);
    endtask
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [55:0] s_tdata;
  logic [63:0] m_tdata;
  exec_scoreboard sb;
  int send_idle, recv_idle;
  bit hold_recv;
  longint cycles;

  typed_stack_machine_execute u_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  task send(tsme_pkg::op_t op, logic [31:0] imm, logic [15:0] addr = 16'($urandom));
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'd0, addr, imm, op};
    do @(posedge clk); while (!s_tready);
    sb.note_instruction(op, imm, addr);
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(2);
      1: return 32'h7fff_ffff - $urandom_range(2);
      2: return $urandom_range(40);
      3: return -$urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  task random_instruction();
    tsme_pkg::op_t op;
    int k;
    k = $urandom_range(99);
    if (sb.sp < 3 && k < 50)
      op = ($urandom_range(2) == 0) ? tsme_pkg::OP_LDI :
           tsme_pkg::op_t'($urandom_range(tsme_pkg::OP_LDC, tsme_pkg::OP_LDTRUE));
    else if (sb.sp > 40 && k < 40) op = tsme_pkg::OP_DROP;
    else op = tsme_pkg::op_t'($urandom_range(31));
    send(op, rand_value(), 16'($urandom));
  endtask

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = 0; m_tready = 0; hold_recv = 0;
    cycles = 0; send_idle = 0; recv_idle = 0;
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty-stack errors, then overflow, division, type, shift and branch cases
    send(tsme_pkg::OP_DROP, 0); send(tsme_pkg::OP_RET, 0);
    send(tsme_pkg::OP_ADD, 0); send(tsme_pkg::OP_BRT, 0);
    send(tsme_pkg::OP_LDI, 32'h7fff_ffff); send(tsme_pkg::OP_LDI, 1);
    send(tsme_pkg::OP_ADD, 0);
    send(tsme_pkg::OP_DROP, 0); send(tsme_pkg::OP_LDI, 32'h8000_0000);
    send(tsme_pkg::OP_INV, 0);
    send(tsme_pkg::OP_LDI, -1); send(tsme_pkg::OP_IDIV, 0); send(tsme_pkg::OP_DROP, 0);
    send(tsme_pkg::OP_LDI, 32'h8000_0000); send(tsme_pkg::OP_LDI, 0);
    send(tsme_pkg::OP_MOD, 0);
    send(tsme_pkg::OP_DROP, 0); send(tsme_pkg::OP_LDC, 32'hffff_ff80);
    send(tsme_pkg::OP_ADD, 0);
    send(tsme_pkg::OP_LDI, 40); send(tsme_pkg::OP_SHR, 0);
    send(tsme_pkg::OP_CALL, 32'h1234, 16'hffff);
    send(tsme_pkg::OP_RET, 0); send(tsme_pkg::OP_LDTRUE, 0);
    send(tsme_pkg::OP_BRF, 32'habcd);
    for (int i = 0; i < 66; i++) send(tsme_pkg::OP_LDFALSE, 0);
    for (int i = 0; i < 17; i++) send(tsme_pkg::OP_CALL, $urandom, 16'($urandom));
    drain();
    for (int i = 0; i < 70; i++) send(tsme_pkg::OP_DROP, 0);
    for (int i = 0; i < 17; i++) send(tsme_pkg::OP_RET, 0);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 23 : (ph == 1) ? 77 : 0;
      recv_idle = (ph == 0) ? 77 : (ph == 1) ? 23 : 0;
      for (int i = 0; i < 85; i++) random_instruction();
      if (ph == 0) begin
        fork
          begin
            hold_recv = 1;
            repeat (300) @(posedge clk);
            hold_recv = 0;
          end
          for (int i = 0; i < 10; i++) random_instruction();
        join
      end
      drain();
    end
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tsme_pkg.sv
rtl/core/tsme_div.sv
rtl/core/tsme_datapath.sv
rtl/core/tsme_ctrl.sv
rtl/core/typed_stack_machine_execute.sv
dv/testbench.sv
